// ----- src/sync_len_crc8_frame_decoder_macros.svh -----
// Assertion helpers for the frame decoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SYNC_LEN_CRC8_FRAME_DECODER_MACROS_SVH
`define SYNC_LEN_CRC8_FRAME_DECODER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SLCFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame decoder check failed");

// Check that a condition implies another in the next cycle
`define SLCFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame decoder check failed");

`endif

// ----- src/slcfd_pkg.sv -----
`default_nettype none

package slcfd_pkg;

    // Result status codes
    localparam logic [1:0] STAT_HDR  = 2'd0;
    localparam logic [1:0] STAT_DATA = 2'd1;
    localparam logic [1:0] STAT_CRC  = 2'd2;
    localparam logic [1:0] STAT_OVER = 2'd3;

    // Sync byte after reset
    localparam logic [7:0] SYNC_RESET = 8'hC6;

    // CRC-8 generator polynomial
    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CHECK,
        ST_PAY_RD,
        ST_PAY_WAIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // sync found: clear crc
        logic cap_type;  // capture type byte
        logic cap_len;   // capture length byte
        logic feed;      // take one payload byte
        logic check;     // compare crc, load header or error result
        logic rd_issue;  // read payload store at read index
        logic load_pay;  // load payload result, advance read index
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sync_hit;    // input byte equals sync value
        logic len_zero;    // input byte is zero
        logic cnt_done;    // this payload byte is the last one
        logic pay_follow;  // good frame with payload to send
        logic pay_last;    // read index points at final payload byte
        logic out_free;    // output register can take a result
    } sts_t;

    // One byte through the CRC, msb first, no reflection
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/slcfd_ctrl.sv -----
`default_nettype none

module slcfd_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire slcfd_pkg::sts_t   sts,
    output slcfd_pkg::cmd_t        cmd,
    output logic                   in_stall
);

`include "sync_len_crc8_frame_decoder_macros.svh"

    slcfd_pkg::state_t state_reg;
    slcfd_pkg::state_t state_next;
    logic              acc;

    // Hold the phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slcfd_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Stall input while emitting payload, or at the crc byte while a result waits
    always_comb
    begin
        case (state_reg)
            slcfd_pkg::ST_PAY_RD:   in_stall = 1'b1;
            slcfd_pkg::ST_PAY_WAIT: in_stall = 1'b1;
            slcfd_pkg::ST_CHECK:    in_stall = !sts.out_free;
            default:                in_stall = 1'b0;
        endcase
    end

    assign acc = in_valid && !in_stall;

    // Next phase and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            slcfd_pkg::ST_HUNT:
            begin
                if (acc && sts.sync_hit)
                begin
                    cmd.start  = 1'b1;
                    state_next = slcfd_pkg::ST_TYPE;
                end
            end
            slcfd_pkg::ST_TYPE:
            begin
                if (acc)
                begin
                    cmd.cap_type = 1'b1;
                    state_next   = slcfd_pkg::ST_LEN;
                end
            end
            slcfd_pkg::ST_LEN:
            begin
                if (acc)
                begin
                    cmd.cap_len = 1'b1;
                    state_next  = sts.len_zero ? slcfd_pkg::ST_CHECK : slcfd_pkg::ST_DATA;
                end
            end
            slcfd_pkg::ST_DATA:
            begin
                if (acc)
                begin
                    cmd.feed = 1'b1;
                    if (sts.cnt_done)
                    begin
                        state_next = slcfd_pkg::ST_CHECK;
                    end
                end
            end
            slcfd_pkg::ST_CHECK:
            begin
                if (acc)
                begin
                    cmd.check  = 1'b1;
                    state_next = sts.pay_follow ? slcfd_pkg::ST_PAY_RD : slcfd_pkg::ST_HUNT;
                end
            end
            slcfd_pkg::ST_PAY_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = slcfd_pkg::ST_PAY_WAIT;
            end
            slcfd_pkg::ST_PAY_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_pay = 1'b1;
                    state_next   = sts.pay_last ? slcfd_pkg::ST_HUNT : slcfd_pkg::ST_PAY_RD;
                end
            end
            default:
            begin
                state_next = slcfd_pkg::ST_HUNT;
            end
        endcase
    end

    // Never overwrite a result that is still waiting
    `SLCFD_ASSERT_SAME(a_pay_load_free, cmd.load_pay, sts.out_free)
    `SLCFD_ASSERT_SAME(a_check_load_free, cmd.check, sts.out_free)
    // A store read is always followed by its wait state
    `SLCFD_ASSERT_NEXT(a_read_then_wait, state_reg == slcfd_pkg::ST_PAY_RD,
        state_reg == slcfd_pkg::ST_PAY_WAIT)
    // A frame with nothing more to send goes straight back to hunting
    `SLCFD_ASSERT_NEXT(a_check_to_hunt, cmd.check && !sts.pay_follow,
        state_reg == slcfd_pkg::ST_HUNT)

endmodule

`default_nettype wire

// ----- src/slcfd_datapath.sv -----
`default_nettype none

module slcfd_datapath
#(
    parameter int MAX_PAYLOAD = 63,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic [7:0]  rx_byte,
    input  wire slcfd_pkg::cmd_t cmd,
    output slcfd_pkg::sts_t  sts,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic [1:0]       status,
    output logic [7:0]       frame_type,
    output logic [7:0]       frame_len,
    output logic [7:0]       data_byte,
    output logic             last,
    output logic [15:0]      good_frames,
    output logic [15:0]      bad_frames
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    logic [7:0]             sync_reg;
    logic [7:0]             type_reg;
    logic [7:0]             len_reg;
    logic [7:0]             cnt_reg;
    logic [7:0]             crc_reg;
    logic [7:0]             crc_next;
    logic [COUNT_WIDTH-1:0] good_reg;
    logic [COUNT_WIDTH-1:0] good_next;
    logic [COUNT_WIDTH-1:0] bad_reg;
    logic [COUNT_WIDTH-1:0] bad_next;
    logic [31:0]            good_wide;
    logic [31:0]            bad_wide;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [7:0]             rd_data_reg;
    logic [7:0]             mem [MAX_PAYLOAD];
    logic                   over;
    logic                   crc_ok;
    logic                   store_en;

    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [7:0]             frame_type_reg;
    logic [7:0]             frame_len_reg;
    logic [7:0]             data_byte_reg;
    logic                   last_reg;
    logic [15:0]            good_frames_reg;
    logic [15:0]            bad_frames_reg;

    // Frame checks
    assign crc_next = slcfd_pkg::crc8_feed(crc_reg, rx_byte);
    assign over     = len_reg > MAX_B;
    assign crc_ok   = crc_reg == rx_byte;
    assign store_en = cmd.feed && (len_reg <= MAX_B) && (cnt_reg < MAX_B);

    // Counter values after this frame
    always_comb
    begin
        good_next = good_reg;
        bad_next  = bad_reg;
        if (over || !crc_ok)
        begin
            bad_next = bad_reg + COUNT_WIDTH'(1);
        end
        else
        begin
            good_next = good_reg + COUNT_WIDTH'(1);
        end
    end

    assign good_wide = 32'(good_next);
    assign bad_wide  = 32'(bad_next);

    // Status for the controller
    always_comb
    begin
        sts.sync_hit   = rx_byte == sync_reg;
        sts.len_zero   = rx_byte == 8'd0;
        sts.cnt_done   = ({1'b0, cnt_reg} + 9'd1) >= {1'b0, len_reg};
        sts.pay_follow = !over && crc_ok && (len_reg != 8'd0);
        sts.pay_last   = (8'(rd_idx_reg) + 8'd1) == len_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // Sync value register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= slcfd_pkg::SYNC_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_reg <= cfg_wr_data;
        end
    end

    // Frame fields, crc, byte count, counters and read index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg   <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            crc_reg    <= '0;
            good_reg   <= '0;
            bad_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                crc_reg <= '0;
            end
            if (cmd.cap_type)
            begin
                type_reg <= rx_byte;
                crc_reg  <= crc_next;
            end
            if (cmd.cap_len)
            begin
                len_reg <= rx_byte;
                cnt_reg <= '0;
                crc_reg <= crc_next;
            end
            if (cmd.feed)
            begin
                cnt_reg <= cnt_reg + 8'd1;
                crc_reg <= crc_next;
            end
            if (cmd.check)
            begin
                cnt_reg    <= '0;
                good_reg   <= good_next;
                bad_reg    <= bad_next;
                rd_idx_reg <= '0;
            end
            if (cmd.load_pay)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
    end

    // Payload store: write while receiving, registered read while emitting
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.check || cmd.load_pay)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            if (over)
            begin
                status_reg <= slcfd_pkg::STAT_OVER;
            end
            else if (!crc_ok)
            begin
                status_reg <= slcfd_pkg::STAT_CRC;
            end
            else
            begin
                status_reg <= slcfd_pkg::STAT_HDR;
            end
            frame_type_reg  <= type_reg;
            frame_len_reg   <= len_reg;
            data_byte_reg   <= '0;
            last_reg        <= !sts.pay_follow;
            good_frames_reg <= good_wide[15:0];
            bad_frames_reg  <= bad_wide[15:0];
        end
        else if (cmd.load_pay)
        begin
            status_reg    <= slcfd_pkg::STAT_DATA;
            data_byte_reg <= rd_data_reg;
            last_reg      <= sts.pay_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign frame_type  = frame_type_reg;
    assign frame_len   = frame_len_reg;
    assign data_byte   = data_byte_reg;
    assign last        = last_reg;
    assign good_frames = good_frames_reg;
    assign bad_frames  = bad_frames_reg;

endmodule

`default_nettype wire

// ----- src/sync_len_crc8_frame_decoder.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    rx_byte
// output    out        out_valid / out_stall  status, frame_type, frame_len, data_byte,
//                                             last, good_frames, bad_frames
// config    in         cfg_wr_en              cfg_wr_data (sync value)
//
// Each received byte is taken when in_valid is high and in_stall is low; only the crc
// byte gives results. After a good frame each payload result passes a store read, then
// an output register load, and input stalls after the crc byte while payload is emitted.
// The crc byte itself stalls while an earlier result still waits in the output register.
// Reset clears the phase, frame fields, counters and output valid; the payload
// store is not cleared and is only read where the current frame wrote it.

module sync_len_crc8_frame_decoder
#(
    parameter int MAX_PAYLOAD = 63,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [7:0]       frame_type,
    output logic [7:0]       frame_len,
    output logic [7:0]       data_byte,
    output logic             last,
    output logic [15:0]      good_frames,
    output logic [15:0]      bad_frames
);

    slcfd_pkg::cmd_t cmd;
    slcfd_pkg::sts_t sts;

    // Phase sequencing
    slcfd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Frame fields, crc, store and output register
    slcfd_datapath
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .frame_type  (frame_type),
        .frame_len   (frame_len),
        .data_byte   (data_byte),
        .last        (last),
        .good_frames (good_frames),
        .bad_frames  (bad_frames)
    );

endmodule

`default_nettype wire
